/* rtl/nvme_io_queue_sequencer_defines.svh */
// Assertion helpers for the queue sequencer.
// Both expect clk_i and rst_ni in the enclosing scope.
`ifndef NVME_IO_QUEUE_SEQUENCER_DEFINES_SVH
`define NVME_IO_QUEUE_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define NVMEQS_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NVMEQS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/nvmeqs_pkg.sv */
package nvmeqs_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF  = 8;
  localparam int unsigned BUFFER_PAGES_DEF = 16;

  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned SHIFT_MIN  = 9;
  localparam int unsigned SHIFT_MAX  = 12;

  localparam logic [3:0]  SECTOR_SHIFT_RST = 4'd9;
  localparam logic [31:0] POLL_LIMIT_RST   = 32'd50000000;

  localparam logic [1:0] OPC_WRITE = 2'h1;
  localparam logic [1:0] OPC_READ  = 2'h2;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_POLL  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_SUBMIT  = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_ERROR   = 2'd2,
    KIND_TIMEOUT = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_SECTOR_SHIFT  = 2'd0,
    REG_DMA_BASE      = 2'd1,
    REG_PRP_LIST_BASE = 2'd2,
    REG_POLL_LIMIT    = 2'd3
  } reg_idx_e;

  // what one chunk issue produces
  typedef struct packed {
    logic [63:0] next_lba;
    logic [31:0] next_remaining;
    logic [6:0]  nlb;
    logic [4:0]  pages;
    logic [63:0] prp2;
  } chunk_t;

endpackage

/* rtl/nvmeqs_chunk_calc.sv */
module nvmeqs_chunk_calc #(
  parameter int unsigned BUFFER_PAGES = nvmeqs_pkg::BUFFER_PAGES_DEF
) (
  input  logic [3:0]          sector_shift_i,
  input  logic [63:0]         lba_i,
  input  logic [31:0]         remaining_i,
  input  logic [63:0]         dma_base_i,
  input  logic [63:0]         prp_list_base_i,
  output nvmeqs_pkg::chunk_t  chunk_o
);
  import nvmeqs_pkg::*;

  localparam int unsigned BufBytes = BUFFER_PAGES * PAGE_BYTES;
  localparam int unsigned BytesW   = $clog2(BufBytes + 1);
  localparam int unsigned ChunkW   = $clog2(BUFFER_PAGES * (PAGE_BYTES >> SHIFT_MIN) + 1);
  localparam int unsigned PageW    = BytesW - PAGE_SHIFT;

  logic [3:0]          eff_shift;
  logic [ChunkW-1:0]   max_chunk;
  logic [ChunkW-1:0]   chunk;
  logic [ChunkW-1:0]   nlb;
  logic [ChunkW+6:0]   nlb_ext;
  logic [BytesW-1:0]   nbytes;
  logic [PageW-1:0]    pages;
  logic [PageW+4:0]    pages_ext;

  always_comb begin
    // out-of-range sector sizes fall back to 512 bytes
    eff_shift = (sector_shift_i inside {[SHIFT_MIN:SHIFT_MAX]}) ?
                sector_shift_i : 4'(SHIFT_MIN);
    max_chunk = ChunkW'(BytesW'(BufBytes) >> eff_shift);
    chunk     = (remaining_i > 32'(max_chunk)) ? max_chunk : remaining_i[ChunkW-1:0];
    nbytes    = BytesW'(chunk) << eff_shift;
    // round up to whole pages
    pages     = nbytes[BytesW-1:PAGE_SHIFT] + PageW'(|nbytes[PAGE_SHIFT-1:0]);
    nlb       = chunk - ChunkW'(1);
    nlb_ext   = (ChunkW + 7)'(nlb);
    pages_ext = (PageW + 5)'(pages);

    chunk_o.next_lba       = lba_i + 64'(chunk);
    chunk_o.next_remaining = remaining_i - 32'(chunk);
    chunk_o.nlb            = nlb_ext[6:0];
    chunk_o.pages          = pages_ext[4:0];
    if (32'(nbytes) <= 32'(PAGE_BYTES)) begin
      chunk_o.prp2 = '0;
    end else if (32'(nbytes) <= 32'(2 * PAGE_BYTES)) begin
      chunk_o.prp2 = dma_base_i + 64'(PAGE_BYTES);
    end else begin
      chunk_o.prp2 = prp_list_base_i;
    end
  end

endmodule

/* rtl/nvme_io_queue_sequencer.sv */
// Host-side sequencer for one NVMe I/O submission/completion queue pair.
// Input channel (in_valid_i / in_stall_o): a word is either a start
// (command 0: start_lba, sector_total, is_write) or a poll (command 1:
// completion dword 3 read at the current completion head).
// Output channel (out_valid_o / out_stall_i): at most one result word per
// input word: a submit command with the new SQ tail, done, error status,
// or timeout. Both doorbells are carried in every result.
// Config port: cfg_we_i writes register cfg_idx_i (sector shift, DMA base,
// PRP list base, poll limit); write it only while no word is in flight.
// An accepted word goes to the input register; it is processed from there
// and its result goes to the result register. Throughput is one word per
// cycle while the receiver does not stall; each register holds one word.
// When the receiver stalls, the held result stays put; the input register
// keeps going for words that produce no result, and otherwise stalls.
// Reset clears the queue pointers, sets the expected phase to 1, idles the
// sequencer and loads the register defaults (512-byte sectors, 50M polls).
module nvme_io_queue_sequencer #(
  parameter int unsigned QUEUE_DEPTH  = nvmeqs_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned BUFFER_PAGES = nvmeqs_pkg::BUFFER_PAGES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [63:0]         cfg_wdata_i,

  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                command_i,
  input  logic [63:0]         start_lba_i,
  input  logic [31:0]         sector_total_i,
  input  logic                is_write_i,
  input  logic [31:0]         completion_dw3_i,

  output logic                out_valid_o,
  input  logic                out_stall_i,
  output nvmeqs_pkg::kind_e   result_kind_o,
  output logic [1:0]          opcode_o,
  output logic [15:0]         command_id_o,
  output logic [63:0]         chunk_lba_o,
  output logic [6:0]          block_count_minus_one_o,
  output logic [63:0]         prp_first_o,
  output logic [63:0]         prp_second_o,
  output logic [4:0]          data_pages_o,
  output logic [2:0]          sq_doorbell_o,
  output logic [2:0]          cq_doorbell_o,
  output logic [14:0]         nvme_status_o
);
  import nvmeqs_pkg::*;

`include "nvme_io_queue_sequencer_defines.svh"

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    kind_e       kind;
    logic [1:0]  opcode;
    logic [15:0] cid;
    logic [63:0] lba;
    logic [6:0]  nlb;
    logic [63:0] prp1;
    logic [63:0] prp2;
    logic [4:0]  pages;
    logic [2:0]  sq_db;
    logic [2:0]  cq_db;
    logic [14:0] status;
  } result_t;

  // config
  logic [3:0]  sector_shift_q;
  logic [63:0] dma_base_q, prp_list_base_q;
  logic [31:0] poll_limit_q;

  // input register
  logic        in_valid_q;
  cmd_e        in_cmd_q;
  logic [63:0] in_lba_q;
  logic [31:0] in_cnt_q;
  logic        in_wr_q;
  logic [31:0] in_dw3_q;

  // sequencer state
  logic [PtrW-1:0] sq_tail_q, sq_tail_d, cq_head_q, cq_head_d;
  logic            expected_phase_q, expected_phase_d;
  logic [15:0]     next_cid_q, next_cid_d;
  logic            busy_q, busy_d, writing_q, writing_d;
  logic [63:0]     next_lba_q, next_lba_d;
  logic [31:0]     remaining_q, remaining_d, poll_count_q, poll_count_d;

  // result register
  logic        out_valid_q;
  result_t     out_q;

  logic            accept, fire, res_valid, issue;
  result_t         res;
  logic [63:0]     calc_lba;
  logic [31:0]     calc_rem;
  chunk_t          chunk;
  logic [PtrW-1:0] tail_next, head_next;
  logic [PtrW+2:0] tail_ext, head_ext;
  logic [14:0]     status;

  assign fire       = in_valid_q && (!res_valid || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  assign calc_lba = (in_cmd_q == CMD_START) ? in_lba_q : next_lba_q;
  assign calc_rem = (in_cmd_q == CMD_START) ? in_cnt_q : remaining_q;

  nvmeqs_chunk_calc #(
    .BUFFER_PAGES(BUFFER_PAGES)
  ) u_chunk (
    .sector_shift_i (sector_shift_q),
    .lba_i          (calc_lba),
    .remaining_i    (calc_rem),
    .dma_base_i     (dma_base_q),
    .prp_list_base_i(prp_list_base_q),
    .chunk_o        (chunk)
  );

  assign tail_next = (sq_tail_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : sq_tail_q + PtrW'(1);
  assign head_next = (cq_head_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : cq_head_q + PtrW'(1);
  assign status    = in_dw3_q[31:17];

  always_comb begin
    sq_tail_d        = sq_tail_q;
    cq_head_d        = cq_head_q;
    expected_phase_d = expected_phase_q;
    next_cid_d       = next_cid_q;
    busy_d           = busy_q;
    writing_d        = writing_q;
    next_lba_d       = next_lba_q;
    remaining_d      = remaining_q;
    poll_count_d     = poll_count_q;
    res_valid        = 1'b0;
    issue            = 1'b0;
    res              = '0;

    case (in_cmd_q)
      CMD_START: begin
        if (!busy_q) begin
          res_valid = 1'b1;
          if (in_cnt_q == '0) begin
            res.kind = KIND_DONE;
          end else begin
            busy_d    = 1'b1;
            writing_d = in_wr_q;
            issue     = 1'b1;
          end
        end
      end
      CMD_POLL: begin
        if (busy_q) begin
          if (in_dw3_q[16] != expected_phase_q) begin
            if (poll_count_q > poll_limit_q) begin
              res_valid    = 1'b1;
              res.kind     = KIND_TIMEOUT;
              busy_d       = 1'b0;
              poll_count_d = '0;
            end else if (poll_count_q != '1) begin
              poll_count_d = poll_count_q + 32'd1;
            end
          end else begin
            res_valid    = 1'b1;
            cq_head_d    = head_next;
            poll_count_d = '0;
            if (head_next == '0) begin
              expected_phase_d = !expected_phase_q;
            end
            if (status != '0) begin
              busy_d     = 1'b0;
              res.kind   = KIND_ERROR;
              res.status = status;
            end else if (remaining_q == '0) begin
              busy_d   = 1'b0;
              res.kind = KIND_DONE;
            end else begin
              issue = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase

    if (issue) begin
      next_cid_d   = next_cid_q + 16'd1;
      sq_tail_d    = tail_next;
      next_lba_d   = chunk.next_lba;
      remaining_d  = chunk.next_remaining;
      poll_count_d = '0;
      res.kind     = KIND_SUBMIT;
      res.opcode   = writing_d ? OPC_WRITE : OPC_READ;
      res.cid      = next_cid_q;
      res.lba      = calc_lba;
      res.nlb      = chunk.nlb;
      res.prp1     = dma_base_q;
      res.prp2     = chunk.prp2;
      res.pages    = chunk.pages;
    end

    tail_ext  = (PtrW + 3)'(sq_tail_d);
    head_ext  = (PtrW + 3)'(cq_head_d);
    res.sq_db = tail_ext[2:0];
    res.cq_db = head_ext[2:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sector_shift_q  <= SECTOR_SHIFT_RST;
      dma_base_q      <= '0;
      prp_list_base_q <= '0;
      poll_limit_q    <= POLL_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_SECTOR_SHIFT:  sector_shift_q  <= cfg_wdata_i[3:0];
        REG_DMA_BASE:      dma_base_q      <= cfg_wdata_i;
        REG_PRP_LIST_BASE: prp_list_base_q <= cfg_wdata_i;
        REG_POLL_LIMIT:    poll_limit_q    <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_cmd_q <= cmd_e'(command_i);
      in_lba_q <= start_lba_i;
      in_cnt_q <= sector_total_i;
      in_wr_q  <= is_write_i;
      in_dw3_q <= completion_dw3_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_tail_q        <= '0;
      cq_head_q        <= '0;
      expected_phase_q <= 1'b1;
      next_cid_q       <= '0;
      busy_q           <= 1'b0;
      writing_q        <= 1'b0;
      next_lba_q       <= '0;
      remaining_q      <= '0;
      poll_count_q     <= '0;
    end else if (fire) begin
      sq_tail_q        <= sq_tail_d;
      cq_head_q        <= cq_head_d;
      expected_phase_q <= expected_phase_d;
      next_cid_q       <= next_cid_d;
      busy_q           <= busy_d;
      writing_q        <= writing_d;
      next_lba_q       <= next_lba_d;
      remaining_q      <= remaining_d;
      poll_count_q     <= poll_count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign result_kind_o           = out_q.kind;
  assign opcode_o                = out_q.opcode;
  assign command_id_o            = out_q.cid;
  assign chunk_lba_o             = out_q.lba;
  assign block_count_minus_one_o = out_q.nlb;
  assign prp_first_o             = out_q.prp1;
  assign prp_second_o            = out_q.prp2;
  assign data_pages_o            = out_q.pages;
  assign sq_doorbell_o           = out_q.sq_db;
  assign cq_doorbell_o           = out_q.cq_db;
  assign nvme_status_o           = out_q.status;

  // unmatched polls are only counted while a transfer is open
  `NVMEQS_ASSERT(a_poll_count_busy, poll_count_q != '0, busy_q, "poll count set while idle")
  `NVMEQS_ASSERT_NEXT(a_submit_busy, fire && res_valid && res.kind == KIND_SUBMIT, busy_q, "submit without busy")
  // phase only flips when the head wraps
  `NVMEQS_ASSERT(a_phase_wrap, expected_phase_q != $past(expected_phase_q), cq_head_q == '0, "phase flip off wrap")

endmodule
